[hw/rtl/imu_trapezoid_gesture_detector_assert.svh]
// assertion macros for the gesture detector checker
`ifndef IMU_TRAPEZOID_GESTURE_DETECTOR_ASSERT_SVH
`define IMU_TRAPEZOID_GESTURE_DETECTOR_ASSERT_SVH
// property must hold on every clock edge outside reset
`define ITG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// property checked even during reset
`define ITG_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

[hw/rtl/itgd_pkg.sv]
`default_nettype none
package itgd_pkg;
    localparam logic [24:0] ACC_K = 25'd822922;
    localparam logic [24:0] HP_A = 25'd16620571;
    localparam logic [24:0] HP_P = 25'd16463926;
    localparam logic [24:0] HALF_T = 25'd83886;
    localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;

    typedef enum logic [2:0] {
        CFG_FIRST_X  = 3'd0,
        CFG_FIRST_Y  = 3'd1,
        CFG_SECOND_X = 3'd2,
        CFG_SECOND_Y = 3'd3,
        CFG_BAND     = 3'd4,
        CFG_THIRD_X  = 3'd5,
        CFG_THIRD_Y  = 3'd6,
        CFG_CALIB    = 3'd7
    } t_cfg_idx;

    // detector step as shown on the result word
    typedef enum logic [1:0] {
        STEP_IDLE   = 2'd0,
        STEP_FIRST  = 2'd1,
        STEP_SECOND = 2'd2,
        STEP_DETECT = 2'd3
    } t_step;

    // one accepted sample waiting for the back end
    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic [31:0]        tick;
    } t_item;

    // result word
    typedef struct packed {
        logic signed [31:0] rel_x;
        logic signed [31:0] rel_y;
        logic [1:0]         step;
        logic               pulse;
        logic               pending;
    } t_res;

    function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
        if (x > 64'(MAX48)) return MAX48;
        if (x < 64'(MIN48)) return MIN48;
        return x[47:0];
    endfunction
endpackage
`default_nettype wire

[hw/rtl/itgd_front.sv]
`default_nettype none
// sample intake: masks failed reads and queues up to two samples
module itgd_front #(
    parameter int ACCEL_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    output logic                      o_full,
    input  wire logic signed [15:0]   i_ax,
    input  wire logic signed [15:0]   i_ay,
    input  wire logic                 i_ok,
    input  wire logic [31:0]          i_tick,
    output logic                      o_valid,
    output itgd_pkg::t_item           o_item,
    input  wire logic                 i_take
);
    import itgd_pkg::*;
    t_item r_q [2];
    logic [1:0] r_cnt;
    logic r_rd, r_wr;
    t_item n_it;
    logic wr_en, rd_en;

    function automatic logic signed [15:0] clip(input logic signed [15:0] a);
        logic signed [ACCEL_BITS-1:0] t;
        t = a[ACCEL_BITS-1:0];
        return 16'(t);
    endfunction

    always_comb begin
        n_it.ax = i_ok ? clip(i_ax) : '0;
        n_it.ay = i_ok ? clip(i_ay) : '0;
        n_it.tick = i_tick;
    end
    assign o_full = r_cnt[1];
    assign wr_en = i_push && !o_full;
    assign o_valid = r_cnt != 2'd0;
    assign rd_en = i_take && o_valid;
    assign o_item = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (wr_en) r_q[r_wr] <= n_it;
        if (!i_rst_n) begin
            r_cnt <= '0; r_rd <= 1'b0; r_wr <= 1'b0;
        end else begin
            if (wr_en) r_wr <= ~r_wr;
            if (rd_en) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(wr_en) - 2'(rd_en);
        end
    end
endmodule
`default_nettype wire

[hw/rtl/itgd_mulq.sv]
`default_nettype none
// rounded product v*k/2^sh, 48-bit value split into two 24-bit halves
module itgd_mulq (
    input  wire logic               i_clk,
    input  wire logic signed [47:0] i_v,
    input  wire logic [24:0]        i_k,
    input  wire logic [4:0]         i_sh,
    input  wire logic               i_hi,
    output logic signed [63:0]      o_p
);
    logic [47:0] u;
    logic signed [24:0] hi;
    logic [23:0] lo;
    logic signed [50:0] r_hp;
    logic [48:0] r_lp;
    logic [4:0] r_sh;
    logic [48:0] rl;

    assign u = i_v + 48'h8000_0000_0000;
    assign hi = $signed({1'b0, u[47:24]}) - 25'sd8388608;
    assign lo = u[23:0];
    // both halves latched in the issue phase, sum ready in the next phase
    always_ff @(posedge i_clk) begin
        if (i_hi) begin
            r_sh <= i_sh;
            r_hp <= 51'(hi) * 51'($signed({1'b0, i_k}));
            r_lp <= 49'(lo) * 49'(i_k);
        end
    end
    always_comb begin
        rl = (r_sh == 5'd0) ? r_lp : ((r_lp + (49'd1 << (r_sh - 5'd1))) >> r_sh);
        o_p = (64'(r_hp) <<< (5'd24 - r_sh)) + 64'(rl);
    end
endmodule
`default_nettype wire

[hw/rtl/itgd_back.sv]
`default_nettype none
// filter sequencer and gesture detector, one shared multiplier
module itgd_back #(
    parameter int FRAC_BITS    = 16,
    parameter int HOLD_TICKS   = 2,
    parameter int RETURN_TICKS = 20
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire itgd_pkg::t_item         i_item,
    output logic                         o_take,
    input  wire logic                    i_cfg_we,
    input  wire logic [2:0]              i_cfg_idx,
    input  wire logic [31:0]             i_cfg_data,
    output logic                         o_res_valid,
    output itgd_pkg::t_res               o_res,
    input  wire logic                    i_res_pop
);
    import itgd_pkg::*;
    typedef enum logic [2:0] {S_IDLE, S_V, S_HV, S_D, S_HD, S_DET} t_st;
    t_st r_st;
    logic r_ax, r_ph, r_op;
    logic r_full;
    t_item r_it;
    logic signed [15:0] r_pa [2];
    logic signed [47:0] r_v [2], r_pv [2], r_phv [2], r_d [2], r_pd [2], r_phd [2];
    logic signed [31:0] r_off [2], r_abs [2], r_rel [2];
    logic signed [47:0] r_acc;
    t_step r_ds;
    logic [31:0] r_lct;
    logic r_need;
    logic [15:0] r_cfg [7];
    logic [31:0] r_calib;
    logic signed [31:0] r_rx, r_ry;
    logic r_pulse;

    logic signed [47:0] m_v;
    logic [24:0] m_k;
    logic [4:0] m_sh;
    logic signed [63:0] m_p;
    logic signed [15:0] a_cur;

    itgd_mulq u_mul (.i_clk(i_clk), .i_v(m_v), .i_k(m_k), .i_sh(m_sh),
                     .i_hi(r_ph == 1'b0), .o_p(m_p));

    assign a_cur = r_ax ? r_it.ay : r_it.ax;
    assign o_take = (r_st == S_IDLE) && i_valid && !r_full;
    assign o_res_valid = r_full;

    // operand for current step, op selects first or second product
    always_comb begin
        m_sh = 5'd24;
        m_k = HP_A;
        m_v = '0;
        unique case (r_st)
            S_V: begin
                m_v = 48'(r_pa[r_ax]) + 48'(a_cur);
                m_k = ACC_K; m_sh = 5'(24 - FRAC_BITS);
            end
            S_HV: begin
                m_v = r_op ? r_phv[r_ax] : sat48(64'(r_v[r_ax]) - 64'(r_pv[r_ax]));
                m_k = r_op ? HP_P : HP_A;
            end
            S_D: begin
                m_v = sat48(64'(r_acc) + 64'(r_phv[r_ax]));
                m_k = HALF_T;
            end
            S_HD: begin
                m_v = r_op ? r_phd[r_ax] : sat48(64'(r_d[r_ax]) - 64'(r_pd[r_ax]));
                m_k = r_op ? HP_P : HP_A;
            end
            default: ;
        endcase
    end

    logic signed [63:0] ipart;
    logic signed [47:0] df;
    logic signed [31:0] absv, relv;
    logic signed [63:0] relw;
    always_comb begin
        df = sat48(64'(r_acc) + m_p);
        ipart = df[47] ? -64'((-64'(df)) >>> FRAC_BITS) : 64'(df) >>> FRAC_BITS;
        absv = (ipart > 64'sd2147483647) ? 32'sh7FFFFFFF :
               (ipart < -64'sd2147483648) ? 32'sh80000000 : ipart[31:0];
        relw = 64'(absv) - 64'(r_off[r_ax]);
        relv = (relw > 64'sd2147483647) ? 32'sh7FFFFFFF :
               (relw < -64'sd2147483648) ? 32'sh80000000 : relw[31:0];
    end

    logic [31:0] el;
    logic signed [32:0] dy;
    logic c0, c1, c2, c3;
    always_comb begin
        el = r_it.tick - r_lct;
        dy = 33'(r_rel[1]) - 33'($signed(r_cfg[CFG_SECOND_Y]));
        if (dy < 0) dy = -dy;
        c0 = r_ds == STEP_IDLE && 33'(r_rel[0]) < -$signed({17'd0, r_cfg[CFG_FIRST_X]})
             && 33'(r_rel[1]) < -$signed({17'd0, r_cfg[CFG_FIRST_Y]})
             && el > 32'(HOLD_TICKS);
        c1 = r_ds == STEP_FIRST && dy > $signed({17'd0, r_cfg[CFG_BAND]})
             && r_rel[0] > 32'($signed(r_cfg[CFG_SECOND_X])) && el > 32'(HOLD_TICKS);
        c2 = r_ds == STEP_SECOND && r_rel[0] < 32'($signed(r_cfg[CFG_THIRD_X]))
             && r_rel[1] > 32'($signed(r_cfg[CFG_THIRD_Y])) && el > 32'(HOLD_TICKS);
        c3 = r_ds == STEP_DETECT && el > 32'(RETURN_TICKS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ph <= 1'b0; r_op <= 1'b0; r_ax <= 1'b0;
            r_full <= 1'b0; r_ds <= STEP_IDLE; r_lct <= '0; r_need <= 1'b1;
            r_cfg[CFG_FIRST_X] <= 16'd30; r_cfg[CFG_FIRST_Y] <= 16'd50;
            r_cfg[CFG_SECOND_X] <= 16'd60; r_cfg[CFG_SECOND_Y] <= 16'd50;
            r_cfg[CFG_BAND] <= 16'd15; r_cfg[CFG_THIRD_X] <= 16'd30;
            r_cfg[CFG_THIRD_Y] <= 16'd0; r_calib <= 32'd5000;
            for (int i = 0; i < 2; i++) begin
                r_pa[i] <= '0; r_v[i] <= '0; r_pv[i] <= '0; r_phv[i] <= '0;
                r_d[i] <= '0; r_pd[i] <= '0; r_phd[i] <= '0; r_off[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_CALIB) r_calib <= i_cfg_data;
                else r_cfg[i_cfg_idx] <= i_cfg_data[15:0];
            end
            if (r_full && i_res_pop) r_full <= 1'b0;
            // each product: phase 0 issues, phase 1 reads the result
            if (r_st != S_IDLE && r_st != S_DET) r_ph <= ~r_ph;
            unique case (r_st)
                S_IDLE: if (o_take) begin
                    r_it <= i_item; r_ax <= 1'b0; r_st <= S_V; r_ph <= 1'b0;
                end
                S_V: if (r_ph) begin
                    r_v[r_ax] <= sat48(64'(r_v[r_ax]) + m_p);
                    r_pa[r_ax] <= a_cur; r_acc <= '0; r_op <= 1'b0;
                    r_st <= S_HV;
                end
                S_HV: if (r_ph) begin
                    if (!r_op) begin
                        r_acc <= m_p[47:0]; r_op <= 1'b1;
                    end else begin
                        r_acc <= sat48(64'(r_acc) + m_p);
                        r_pv[r_ax] <= r_v[r_ax];
                        r_op <= 1'b0; r_st <= S_D;
                    end
                end
                S_D: if (r_ph) begin
                    r_d[r_ax] <= sat48(64'(r_d[r_ax]) + m_p);
                    r_phv[r_ax] <= r_acc; r_st <= S_HD;
                end
                S_HD: if (r_ph) begin
                    if (!r_op) begin
                        r_acc <= m_p[47:0]; r_op <= 1'b1;
                    end else begin
                        r_pd[r_ax] <= r_d[r_ax]; r_phd[r_ax] <= df;
                        r_abs[r_ax] <= absv; r_rel[r_ax] <= relv; r_op <= 1'b0;
                        if (r_ax) r_st <= S_DET;
                        else begin
                            r_ax <= 1'b1; r_st <= S_V;
                        end
                    end
                end
                S_DET: begin
                    r_pulse <= c2;
                    if (c0) begin r_ds <= STEP_FIRST; r_lct <= r_it.tick; end
                    else if (c1) begin r_ds <= STEP_SECOND; r_lct <= r_it.tick; end
                    else if (c2) begin r_ds <= STEP_DETECT; r_lct <= r_it.tick; end
                    else if (c3) begin r_ds <= STEP_IDLE; r_need <= 1'b1; end
                    else if (r_ds == STEP_IDLE && r_need && r_it.tick >= r_calib) begin
                        r_off[0] <= r_abs[0]; r_off[1] <= r_abs[1]; r_need <= 1'b0;
                    end
                    r_rx <= r_rel[0]; r_ry <= r_rel[1];
                    r_full <= 1'b1; r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
    assign o_res = {r_rx, r_ry, r_ds, r_pulse, r_need};
endmodule
`default_nettype wire

[hw/rtl/imu_trapezoid_gesture_detector.sv]
`default_nettype none
// channel | dir | handshake           | words
// sample  | in  | push / full         | accel x, y, ok, tick
// result  | out | empty / pop         | rel x, y, step, pulse, pending
// config  | in  | i_cfg_we            | index, data
// from a sample accepted into an idle block to its result word: the take, twelve
// products on the shared multiplier in turn, then the detector step
// a new sample starts only after the previous result word has been popped
// a two-entry sample queue keeps accepting while the sequencer runs
// a finished result holds until popped; the sequencer waits on it
// synchronous active-low reset, no clearing pass
module imu_trapezoid_gesture_detector #(
    parameter int FRAC_BITS    = 16,
    parameter int ACCEL_BITS   = 16,
    parameter int HOLD_TICKS   = 2,
    parameter int RETURN_TICKS = 20
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [15:0] i_accel_x,
    input  wire logic signed [15:0] i_accel_y,
    input  wire logic               i_sample_ok,
    input  wire logic [31:0]        i_tick_ms,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [31:0]      o_rel_x,
    output logic signed [31:0]      o_rel_y,
    output logic [1:0]              o_gesture_step,
    output logic                    o_detect_pulse,
    output logic                    o_calib_pending,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data
);
    import itgd_pkg::*;
    t_item it;
    t_res res;
    logic fv, take, rv;

    itgd_front #(.ACCEL_BITS(ACCEL_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_ax(i_accel_x), .i_ay(i_accel_y), .i_ok(i_sample_ok),
        .i_tick(i_tick_ms), .o_valid(fv), .o_item(it), .i_take(take));

    itgd_back #(.FRAC_BITS(FRAC_BITS), .HOLD_TICKS(HOLD_TICKS),
                .RETURN_TICKS(RETURN_TICKS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(fv), .i_item(it),
        .o_take(take), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_res_valid(rv), .o_res(res),
        .i_res_pop(pop));

    assign empty = !rv;
    assign o_rel_x = res.rel_x;
    assign o_rel_y = res.rel_y;
    assign o_gesture_step = res.step;
    assign o_detect_pulse = res.pulse;
    assign o_calib_pending = res.pending;
endmodule
`default_nettype wire

[hw/rtl/itgd_checker.sv]
`default_nettype none
`include "imu_trapezoid_gesture_detector_assert.svh"
// port-level checks
module itgd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       full,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [1:0] o_gesture_step,
    input wire logic       o_detect_pulse
);
    import itgd_pkg::*;
    `ITG_ASSERT(a_pulse_step, i_clk, i_rst_n, !empty && o_detect_pulse |-> o_gesture_step == STEP_DETECT)
    `ITG_ASSERT(a_hold, i_clk, i_rst_n, !empty && !pop |=> !empty)
    `ITG_ASSERT_ALWAYS(a_reset, i_clk, !i_rst_n |=> empty && !full)
endmodule

bind imu_trapezoid_gesture_detector itgd_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .full(full),
    .empty(empty), .pop(pop), .o_gesture_step(o_gesture_step),
    .o_detect_pulse(o_detect_pulse));
`default_nettype wire

[tb/sv/imu_gesture_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module imu_gesture_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    input  wire logic               full,
    input  wire logic signed [15:0] i_accel_x,
    input  wire logic signed [15:0] i_accel_y,
    input  wire logic               i_sample_ok,
    input  wire logic [31:0]        i_tick_ms,
    input  wire logic               empty,
    input  wire logic               pop,
    input  wire logic signed [31:0] i_rel_x,
    input  wire logic signed [31:0] i_rel_y,
    input  wire logic [1:0]         i_step,
    input  wire logic               i_pulse,
    input  wire logic               i_pending,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data,
    output int                      o_fail_count,
    output int                      o_waiting
);
    import itgd_pkg::*;
    localparam int FRAC = 16;
    localparam int ACC_SHIFT = 24 - FRAC;
    localparam int HOLD = 2;
    localparam int RET = 20;
    localparam longint LIM48_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint LIM48_LO = -64'sh0000_8000_0000_0000;

    t_res   expected_words[$];
    logic [31:0] regs [8];
    longint pa [2], vel [2], pvel [2], phv [2], disp [2], pdisp [2], phd [2], offs [2];
    logic [1:0]  det;
    logic [31:0] last_tick;
    logic        need_offset;

    function automatic longint clip48(longint x);
        if (x > LIM48_HI) return LIM48_HI;
        if (x < LIM48_LO) return LIM48_LO;
        return x;
    endfunction

    function automatic longint clip32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // round(v * k / 2^24), ties up
    function automatic longint mul_q24(longint v, longint k);
        longint unsigned u, lo;
        longint hi;
        u = longint'(v) + (64'd1 << 47);
        hi = longint'(u >> 24) - (64'sd1 << 23);
        lo = u & 64'hFF_FFFF;
        return hi * k + longint'((lo * longint'(k) + (64'd1 << 23)) >> 24);
    endfunction

    function automatic longint round_shift(longint x);
        longint unsigned u;
        u = longint'(x) + (64'd1 << 62);
        u = (u + (64'd1 << (ACC_SHIFT - 1))) >> ACC_SHIFT;
        return longint'(u) - longint'(64'd1 << (62 - ACC_SHIFT));
    endfunction

    function automatic longint highpass(longint x, longint xp, longint yp);
        return clip48(mul_q24(clip48(x - xp), longint'(HP_A)) +
                      mul_q24(yp, longint'(HP_P)));
    endfunction

    function automatic longint whole_part(longint d);
        if (d >= 0) return d >>> FRAC;
        return -((-d) >>> FRAC);
    endfunction

    task automatic predict_sample(output t_res w);
        longint a, vf, df, dy;
        longint absp [2], rel [2];
        longint fx, fy, sx, sy, band, tx, ty;
        logic [31:0] elapsed;
        logic pulse;
        elapsed = i_tick_ms - last_tick;
        pulse = 1'b0;
        for (int i = 0; i < 2; i++) begin
            if (!i_sample_ok) a = 0;
            else if (i == 0) a = longint'(i_accel_x);
            else a = longint'(i_accel_y);
            vel[i] = clip48(vel[i] + round_shift((a + pa[i]) * longint'(ACC_K)));
            pa[i] = a;
            vf = highpass(vel[i], pvel[i], phv[i]);
            disp[i] = clip48(disp[i] + mul_q24(clip48(vf + phv[i]), longint'(HALF_T)));
            phv[i] = vf;
            pvel[i] = vel[i];
            df = highpass(disp[i], pdisp[i], phd[i]);
            pdisp[i] = disp[i];
            phd[i] = df;
            absp[i] = clip32(whole_part(df));
            rel[i] = clip32(absp[i] - offs[i]);
        end
        fx = longint'(regs[CFG_FIRST_X][15:0]);
        fy = longint'(regs[CFG_FIRST_Y][15:0]);
        sx = longint'($signed(regs[CFG_SECOND_X][15:0]));
        sy = longint'($signed(regs[CFG_SECOND_Y][15:0]));
        band = longint'(regs[CFG_BAND][15:0]);
        tx = longint'($signed(regs[CFG_THIRD_X][15:0]));
        ty = longint'($signed(regs[CFG_THIRD_Y][15:0]));
        dy = rel[1] - sy;
        if (dy < 0) dy = -dy;
        if (det == STEP_IDLE && rel[0] < -fx && rel[1] < -fy && elapsed > HOLD) begin
            det = STEP_FIRST;
            last_tick = i_tick_ms;
        end else if (det == STEP_FIRST && dy > band && rel[0] > sx && elapsed > HOLD) begin
            det = STEP_SECOND;
            last_tick = i_tick_ms;
        end else if (det == STEP_SECOND && rel[0] < tx && rel[1] > ty && elapsed > HOLD) begin
            det = STEP_DETECT;
            last_tick = i_tick_ms;
            pulse = 1'b1;
        end else if (det == STEP_DETECT && elapsed > RET) begin
            det = STEP_IDLE;
            need_offset = 1'b1;
        end else if (det == STEP_DETECT) begin
            // hold
        end else if (det == STEP_IDLE && need_offset && i_tick_ms >= regs[CFG_CALIB]) begin
            offs[0] = absp[0];
            offs[1] = absp[1];
            need_offset = 1'b0;
        end
        w.rel_x = rel[0][31:0];
        w.rel_y = rel[1][31:0];
        w.step = det;
        w.pulse = pulse;
        w.pending = need_offset;
    endtask

    always @(posedge i_clk) begin
        t_res w, got;
        if (!i_rst_n) begin
            for (int i = 0; i < 2; i++) begin
                pa[i] = 0; vel[i] = 0; pvel[i] = 0; phv[i] = 0;
                disp[i] = 0; pdisp[i] = 0; phd[i] = 0; offs[i] = 0;
            end
            det = STEP_IDLE;
            last_tick = 32'd0;
            need_offset = 1'b1;
            regs[CFG_FIRST_X] = 32'd30;
            regs[CFG_FIRST_Y] = 32'd50;
            regs[CFG_SECOND_X] = 32'd60;
            regs[CFG_SECOND_Y] = 32'd50;
            regs[CFG_BAND] = 32'd15;
            regs[CFG_THIRD_X] = 32'd30;
            regs[CFG_THIRD_Y] = 32'd0;
            regs[CFG_CALIB] = 32'd5000;
            expected_words.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_CALIB) regs[i_cfg_idx] = i_cfg_data;
                else regs[i_cfg_idx] = {16'd0, i_cfg_data[15:0]};
            end
            if (push && !full) begin
                predict_sample(w);
                expected_words.push_back(w);
            end
            if (pop && !empty) begin
                got.rel_x = i_rel_x;
                got.rel_y = i_rel_y;
                got.step = i_step;
                got.pulse = i_pulse;
                got.pending = i_pending;
                if (expected_words.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result word: %p", got);
                end else begin
                    w = expected_words.pop_front();
                    if (got !== w) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: expected %p, got %p", w, got);
                    end
                end
            end
        end
        o_waiting = expected_words.size();
    end
endmodule
`default_nettype wire

[tb/sv/tb_imu_trapezoid_gesture_detector.sv]
`timescale 1ns / 1ps
`default_nettype none
module tb_imu_trapezoid_gesture_detector;
    import itgd_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic signed [15:0] i_accel_x = '0;
    logic signed [15:0] i_accel_y = '0;
    logic               i_sample_ok = 1'b0;
    logic [31:0]        i_tick_ms = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [31:0] o_rel_x, o_rel_y;
    logic [1:0]         o_gesture_step;
    logic               o_detect_pulse, o_calib_pending;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [31:0]        i_cfg_data = '0;
    int                 fail_count, words_waiting;

    logic [31:0] tick_now;   // free-running sample time
    int          burst_left;
    int          pop_pct = 100;
    int          cyc = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    imu_trapezoid_gesture_detector dut (
        .i_clk, .i_rst_n, .push, .full, .i_accel_x, .i_accel_y, .i_sample_ok,
        .i_tick_ms, .empty, .pop, .o_rel_x, .o_rel_y, .o_gesture_step,
        .o_detect_pulse, .o_calib_pending, .i_cfg_we, .i_cfg_idx, .i_cfg_data
    );

    imu_gesture_checker chk (
        .i_clk, .i_rst_n, .push, .full, .i_accel_x, .i_accel_y, .i_sample_ok,
        .i_tick_ms, .empty, .pop, .i_rel_x(o_rel_x), .i_rel_y(o_rel_y),
        .i_step(o_gesture_step), .i_pulse(o_detect_pulse),
        .i_pending(o_calib_pending), .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_fail_count(fail_count), .o_waiting(words_waiting)
    );

    // receiver: pop chance is redrawn from four levels, from rare to always
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc % 300 == 0) begin
            case ($urandom_range(0, 3))
                0: pop_pct <= 100;
                1: pop_pct <= 70;
                2: pop_pct <= 25;
                default: pop_pct <= 5;
            endcase
        end
        pop <= ($urandom_range(0, 99) < pop_pct);
    end

    // one sample word, held until accepted, then maybe a gap
    task automatic send_sample(input logic signed [15:0] ax, input logic signed [15:0] ay,
                               input logic ok, input logic [31:0] tick);
        i_accel_x <= ax;
        i_accel_y <= ay;
        i_sample_ok <= ok;
        i_tick_ms <= tick;
        push <= 1'b1;
        do @(posedge i_clk); while (full);
        if (burst_left == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(0, 12);
        end else begin
            burst_left--;
        end
    endtask

    // next tick: mostly the 10 ms cadence, now and then a jump anywhere
    task automatic next_sample(input logic signed [15:0] ax, input logic signed [15:0] ay,
                               input logic ok);
        if ($urandom_range(0, 99) == 0) tick_now = $urandom();
        else tick_now = tick_now + 32'd10;
        send_sample(ax, ay, ok, tick_now);
    endtask

    // let the block drain before touching registers
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (words_waiting != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // one register per cycle, the enable stays up for the next write
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic write_all(input logic [31:0] fx, fy, sx, sy, band, tx, ty, cal);
        write_reg(CFG_FIRST_X, fx);
        write_reg(CFG_FIRST_Y, fy);
        write_reg(CFG_SECOND_X, sx);
        write_reg(CFG_SECOND_Y, sy);
        write_reg(CFG_BAND, band);
        write_reg(CFG_THIRD_X, tx);
        write_reg(CFG_THIRD_Y, ty);
        write_reg(CFG_CALIB, cal);
        i_cfg_we <= 1'b0;
    endtask

    // segments of steady push in random directions trace out gesture shapes,
    // the rest is raw noise and failed reads
    task automatic random_phase(input int count);
        int n, seg;
        logic signed [15:0] ax, ay;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 4) != 0) begin
                ax = 16'($signed($urandom_range(0, 3000)) - 1500);
                ay = 16'($signed($urandom_range(0, 3000)) - 1500);
                seg = $urandom_range(3, 40);
                for (int k = 0; k < seg && n < count; k++) begin
                    next_sample(ax, ay, $urandom_range(0, 49) != 0);
                    n++;
                end
            end else begin
                seg = $urandom_range(1, 8);
                for (int k = 0; k < seg && n < count; k++) begin
                    next_sample(16'($urandom()), 16'($urandom()), 1'($urandom()));
                    n++;
                end
            end
        end
    endtask

    initial begin
        burst_left = 0;
        tick_now = 32'd4900;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, failed reads, calibration threshold, tick wrap
        next_sample(16'sh7FFF, 16'sh7FFF, 1'b1);
        next_sample(16'sh8000, 16'sh8000, 1'b1);
        next_sample(16'sh7FFF, 16'sh8000, 1'b0);
        next_sample(16'sh0000, 16'shFFFF, 1'b1);
        send_sample(16'sd0, 16'sd0, 1'b1, 32'd4999);
        send_sample(16'sd0, 16'sd0, 1'b1, 32'd5000);
        tick_now = 32'd5000;
        for (int k = 0; k < 8; k++) next_sample(-16'sd2000, -16'sd2000, 1'b1);
        for (int k = 0; k < 6; k++) next_sample(16'sd2500, 16'sd1000, 1'b1);
        send_sample(16'sh5555, 16'shAAAA, 1'b1, 32'hFFFF_FFF0);
        send_sample(16'shAAAA, 16'sh5555, 1'b1, 32'hFFFF_FFFF);
        send_sample(16'sd100, -16'sd100, 1'b1, 32'h0000_0005);
        tick_now = 32'd5;

        random_phase(390);

        // everything open, calibrate at once
        wait_idle();
        write_all(32'd0, 32'd0, 32'hFFFF_8000, 32'd0, 32'd0, 32'd32767,
                  32'hFFFF_8000, 32'd0);
        random_phase(390);

        // tightest limits, never calibrate
        wait_idle();
        write_all(32'd65535, 32'd65535, 32'd32767, 32'hFFFF_8000, 32'd65535,
                  32'hFFFF_8000, 32'd32767, 32'hFFFF_FFFF);
        random_phase(390);

        // random settings with small limits
        wait_idle();
        write_all($urandom_range(0, 60), $urandom_range(0, 60), $urandom_range(0, 60),
                  32'($signed($urandom_range(0, 100)) - 50), $urandom_range(0, 30),
                  $urandom_range(0, 80), 32'($signed($urandom_range(0, 40)) - 20),
                  $urandom_range(0, 40000));
        random_phase(390);

        // defaults again, tick near wrap
        wait_idle();
        write_all(32'd30, 32'd50, 32'd60, 32'd50, 32'd15, 32'd30, 32'd0, 32'd5000);
        tick_now = 32'hFFFF_F000;
        random_phase(390);

        push <= 1'b0;
        @(posedge i_clk);
        while (words_waiting != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** imu_trapezoid_gesture_detector: PASSED **");
        end else begin
            $display("** imu_trapezoid_gesture_detector: FAILED **");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("** imu_trapezoid_gesture_detector: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire
